### hdl/binary_to_ascii_decimal_core_defines.svh
// ----------------------------------------------------------------------------
// binary_to_ascii_decimal_core_defines.svh
// Assertion macros shared by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_ASCII_DECIMAL_CORE_DEFINES_SVH
`define BINARY_TO_ASCII_DECIMAL_CORE_DEFINES_SVH

// same-cycle implication
`define B2AD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define B2AD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/b2ad_pkg.sv
// ----------------------------------------------------------------------------
// b2ad_pkg
// Types and constants of the binary to ASCII decimal converter.
// ----------------------------------------------------------------------------
package b2ad_pkg;

   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 6;

   localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'd48;
   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic digit_shift;
   } cmd_type;

   typedef struct packed {
      logic top_zero;
   } status_type;

endpackage

### hdl/b2ad_ifs.sv
// ----------------------------------------------------------------------------
// b2ad_ifs
// Valid/ready channels of the converter: number in, digit item out.
// ----------------------------------------------------------------------------
interface b2ad_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2ad_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [b2ad_pkg::CHAR_W-1:0]    digit_char;
   logic                           last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

### hdl/b2ad_datapath.sv
// ----------------------------------------------------------------------------
// b2ad_datapath
// Bit-serial double dabble shift registers and digit output shifter.
// ----------------------------------------------------------------------------
module b2ad_datapath #(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_DIGITS  = 10
) (
   input  logic                        clock,
   input  b2ad_pkg::cmd_type           cmd,
   input  logic [VALUE_WIDTH-1:0]      value,
   output b2ad_pkg::status_type        status,
   output logic [b2ad_pkg::CHAR_W-1:0] digit_char
);

   localparam int BCD_W = MAX_DIGITS * b2ad_pkg::DIGIT_W;

   logic [VALUE_WIDTH-1:0]           bin_ff, bin_in;
   logic [BCD_W-1:0]                 bcd_ff, bcd_in;
   logic [BCD_W-1:0]                 adj;
   logic [b2ad_pkg::DIGIT_W-1:0]     top_digit;

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_adj
      assign adj[i*b2ad_pkg::DIGIT_W +: b2ad_pkg::DIGIT_W] =
         (bcd_ff[i*b2ad_pkg::DIGIT_W +: b2ad_pkg::DIGIT_W] >= b2ad_pkg::DABBLE_LIMIT) ?
         bcd_ff[i*b2ad_pkg::DIGIT_W +: b2ad_pkg::DIGIT_W] + b2ad_pkg::DABBLE_ADD :
         bcd_ff[i*b2ad_pkg::DIGIT_W +: b2ad_pkg::DIGIT_W];
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (cmd.load) begin
         bin_in = value;
         bcd_in = '0;
      end else if (cmd.dabble) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
      end else if (cmd.digit_shift) begin
         bcd_in = {bcd_ff[BCD_W-b2ad_pkg::DIGIT_W-1:0], {b2ad_pkg::DIGIT_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit       = bcd_ff[BCD_W-1 -: b2ad_pkg::DIGIT_W];
   assign status.top_zero = (top_digit == '0);
   assign digit_char      = b2ad_pkg::ASCII_ZERO +
                            {{(b2ad_pkg::CHAR_W-b2ad_pkg::DIGIT_W){1'b0}}, top_digit};

endmodule

### hdl/b2ad_ctrl.sv
// ----------------------------------------------------------------------------
// b2ad_ctrl
// Sequencer: load, shift-and-adjust, leading zero skip, digit emit.
// ----------------------------------------------------------------------------
module b2ad_ctrl #(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_DIGITS  = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_last,
   input  b2ad_pkg::status_type status,
   output b2ad_pkg::cmd_type    cmd
);

   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
   localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

   b2ad_pkg::state_type    state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   one_left;

   assign one_left = (dig_cnt_ff == DIG_CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= b2ad_pkg::ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      bit_cnt_in      = bit_cnt_ff;
      dig_cnt_in      = dig_cnt_ff;
      cmd             = '0;
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      rsp_last        = one_left;
      unique case (state_ff)
         b2ad_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = '0;
               state_in   = b2ad_pkg::ST_CONVERT;
            end
         end
         b2ad_pkg::ST_CONVERT: begin
            cmd.dabble = 1'b1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
               dig_cnt_in = DIG_CNT_W'(MAX_DIGITS);
               state_in   = b2ad_pkg::ST_SKIP;
            end
         end
         b2ad_pkg::ST_SKIP: begin
            if (status.top_zero && !one_left) begin
               cmd.digit_shift = 1'b1;
               dig_cnt_in      = dig_cnt_ff - DIG_CNT_W'(1);
            end else begin
               state_in = b2ad_pkg::ST_EMIT;
            end
         end
         b2ad_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.digit_shift = 1'b1;
               dig_cnt_in      = dig_cnt_ff - DIG_CNT_W'(1);
               if (one_left) begin
                  state_in = b2ad_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = b2ad_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/binary_to_ascii_decimal_core.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_decimal_core
// Unsigned binary to ASCII decimal text, one digit item per transfer.
// ----------------------------------------------------------------------------
// Each number taken on req_if comes out on rsp_if as ASCII digits, most
// significant first, leading zeros dropped (zero gives a single '0'), with
// last_digit set on the final digit. Only MAX_DIGITS low decimal digits are
// kept. One number is in flight at a time: after the accept, the
// shift-and-add-3 register takes one step per input bit, then drops the
// leading zeros one by one, turns around and sends one digit per cycle
// while rsp_if is ready.
// ----------------------------------------------------------------------------
`include "binary_to_ascii_decimal_core_defines.svh"

module binary_to_ascii_decimal_core #(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_DIGITS  = 10
) (
   input  logic      clock,
   input  logic      reset,
   b2ad_req_if.sink  req_if,
   b2ad_rsp_if.source rsp_if
);

   b2ad_pkg::cmd_type    cmd;
   b2ad_pkg::status_type status;
   logic                 req_ready;
   logic                 rsp_valid;
   logic                 rsp_last;
   logic [b2ad_pkg::CHAR_W-1:0] digit_char;

   b2ad_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp_last  (rsp_last),
      .status    (status),
      .cmd       (cmd)
   );

   b2ad_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .value      (req_if.value),
      .status     (status),
      .digit_char (digit_char)
   );

   assign req_if.ready      = req_ready;
   assign rsp_if.valid      = rsp_valid;
   assign rsp_if.digit_char = digit_char;
   assign rsp_if.last_digit = rsp_last;

   `B2AD_ASSERT_NOW(a_digit_range, clock, reset, rsp_valid,
      (digit_char >= b2ad_pkg::ASCII_ZERO) && (digit_char <= (b2ad_pkg::ASCII_ZERO + 6'd9)),
      "digit item outside 0..9")
   `B2AD_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready,
      "input taken while digits pending")
   `B2AD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_if.valid && req_ready,
      !req_ready && !rsp_valid, "converter not busy after accept")
   `B2AD_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_valid && rsp_if.ready && rsp_last,
      req_ready, "converter not idle after last digit")

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_to_ascii_decimal_core.
// ----------------------------------------------------------------------------
// Numbers go in on the request channel. Each accepted number is expanded here
// into the decimal digit items it should produce, most significant first,
// with leading zeros dropped. Digit items arriving on the response channel are
// compared in order against that queue. A short table of directed numbers
// comes first, covering zero, single digits, powers of ten, inner zeros and
// the full 32-bit range. Random numbers follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          VALUE_W      = 32;
   localparam int          DIGITS       = 10;
   localparam int          RADIX        = 10;
   localparam int          RANDOM_ITEMS = 80;
   localparam int          DRAIN_CYCLES = 4 * (VALUE_W + DIGITS + 2);
   localparam int          REPORT_LIMIT = 10;
   localparam longint      TIMEOUT_NS   = 2_000_000;

   typedef struct packed {
      logic [b2ad_pkg::CHAR_W-1:0] digit_char;
      logic                        last_digit;
   } digit_item_type;

   typedef digit_item_type digit_list_type[$];

   typedef struct {
      logic [VALUE_W-1:0] value;
      string              text;   // empty: take the predictor's digits
   } number_row_type;

   logic           clock;
   logic           reset;
   bit             no_idle;
   int             mismatches;
   digit_item_type digits_due[$];

   b2ad_req_if #(.VALUE_WIDTH(VALUE_W)) req_ch ();
   b2ad_rsp_if                          rsp_ch ();

   binary_to_ascii_decimal_core #(
      .VALUE_WIDTH (VALUE_W),
      .MAX_DIGITS  (DIGITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   number_row_type directed [] = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'd100,        "100"},
      '{32'd1001,       "1001"},
      '{32'd1000000000, "1000000000"},
      '{32'hFFFFFFFF,   "4294967295"},
      '{32'd0,          "0"},
      '{32'd99,         ""},
      '{32'd999999999,  ""},
      '{32'h80000000,   ""},
      '{32'h7FFFFFFF,   ""},
      '{32'hAAAAAAAA,   ""},
      '{32'h55555555,   ""},
      '{32'h0000FFFF,   ""},
      '{32'hFFFF0000,   ""},
      '{32'd12345,      ""},
      '{32'd4000000000, ""},
      '{32'd1000000007, ""}
   };

   // Decimal text of a number, as digit items.
   function automatic digit_list_type decimal_digits_of(input logic [VALUE_W-1:0] number);
      digit_list_type     chars;
      logic [3:0]         dec [DIGITS];
      logic [VALUE_W-1:0] rest;
      int                 top;
      rest = number;
      top  = 0;
      for (int k = 0; k < DIGITS; k++) begin
         dec[k] = 4'(rest % RADIX);
         rest   = rest / RADIX;
         if (dec[k] != 0)
            top = k;
      end
      for (int k = top; k >= 0; k--)
         chars.push_back('{digit_char: b2ad_pkg::ASCII_ZERO + b2ad_pkg::CHAR_W'(dec[k]),
                           last_digit: (k == 0)});
      return chars;
   endfunction

   function automatic digit_list_type digits_from_text(input string text);
      digit_list_type chars;
      byte            ch;
      for (int i = 0; i < text.len(); i++) begin
         ch = text.getc(i);
         chars.push_back('{digit_char: ch[b2ad_pkg::CHAR_W-1:0],
                           last_digit: (i == text.len() - 1)});
      end
      return chars;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mix of raw 32-bit words, small numbers and decimal-shaped numbers
   // with plenty of inner zeros.
   function automatic logic [VALUE_W-1:0] pick_number();
      longint unsigned acc;
      int              width;
      int              sel;
      sel = $urandom_range(0, 9);
      if (sel < 3)
         return $urandom;
      if (sel < 5)
         return $urandom_range(0, 1000);
      width = $urandom_range(1, DIGITS);
      acc   = $urandom_range(1, 9);
      for (int i = 1; i < width; i++)
         acc = acc * RADIX + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9));
      return acc[VALUE_W-1:0];
   endfunction

   task automatic send_number(input logic [VALUE_W-1:0] number, input digit_list_type due);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= number;
      do @(posedge clock); while (!req_ch.ready);
      foreach (due[i])
         digits_due.push_back(due[i]);
   endtask

   task automatic note_mismatch(input string what, input int exp_val, input int act_val);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_val, act_val);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL binary_to_ascii_decimal_core");
      $finish;
   end

   // Response side stalls.
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      digit_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (digits_due.size() == 0) begin
            note_mismatch("unexpected digit item, digit_char", -1, rsp_ch.digit_char);
         end else begin
            want = digits_due.pop_front();
            if (rsp_ch.digit_char !== want.digit_char)
               note_mismatch("digit_char", want.digit_char, rsp_ch.digit_char);
            if (rsp_ch.last_digit !== want.last_digit)
               note_mismatch("last_digit", want.last_digit, rsp_ch.last_digit);
         end
      end
   end

   initial begin
      logic [VALUE_W-1:0] number;
      digit_list_type     due;
      mismatches = 0;
      no_idle = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].text.len() > 0)
            due = digits_from_text(directed[i].text);
         else
            due = decimal_digits_of(directed[i].value);
         send_number(directed[i].value, due);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = ((n / 20) % 3 == 1);
         number  = pick_number();
         send_number(number, decimal_digits_of(number));
      end
      req_ch.valid <= 1'b0;
      no_idle = 1'b0;

      while (digits_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("PASS binary_to_ascii_decimal_core");
      else
         $display("FAIL binary_to_ascii_decimal_core");
      $finish;
   end

endmodule
